[rtl/zhb_pkg.sv]
package zhb_pkg;

    // Fixed-point format of every data word: signed Q4.20.
    localparam int DW = 24;
    localparam int FB = 20;
    // Quotient bits produced by the divider, one per stage.
    localparam int QW = DW + 1;
    // Width of the rounding accumulators.
    localparam int AW = 2 * DW + 3;
    // Width of the accumulator after the power-of-two part of the divide by six.
    localparam int YW = AW - FB - 1;
    // Bias that makes the shifted accumulator non-negative before the divide by three.
    localparam int BIAS_SH = YW - 2;
    // Reciprocal of three for a 32-bit unsigned dividend, used with a shift of 33.
    localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;
    localparam int RECIP_SH = 33;
    localparam int PW = YW + 32;
    localparam int FW = PW - RECIP_SH;

    typedef logic signed [DW-1:0] data_t;
    typedef logic signed [AW-1:0] acc_t;
    typedef logic signed [2*DW-1:0] prod_t;

    localparam data_t DATA_MAX = data_t'((64'sd1 <<< (DW - 1)) - 1);
    localparam data_t DATA_MIN = data_t'(-(64'sd1 <<< (DW - 1)));
    localparam data_t FX_ONE = data_t'(64'sd1 <<< FB);

    // Configuration register indexes.
    typedef logic [2:0] cfg_idx_t;
    localparam cfg_idx_t REG_SIDE    = 3'd0;
    localparam cfg_idx_t REG_MODE    = 3'd1;
    localparam cfg_idx_t REG_VEL_X   = 3'd2;
    localparam cfg_idx_t REG_VEL_Y   = 3'd3;
    localparam cfg_idx_t REG_DENSITY = 3'd4;

    // Boundary side and condition codes.
    localparam logic [1:0] SIDE_SOUTH = 2'd0;
    localparam logic [1:0] SIDE_NORTH = 2'd1;
    localparam logic [1:0] SIDE_WEST  = 2'd2;
    localparam logic [1:0] SIDE_EAST  = 2'd3;
    localparam logic MODE_VELOCITY = 1'b0;
    localparam logic MODE_DENSITY  = 1'b1;

    // Distributions and flag that ride along with a node.
    typedef struct packed {
        data_t                fo;
        data_t                fp;
        data_t                fm;
        logic signed [DW:0]   d;
        logic                 last;
    } item_t;

    // One divider stage: sign-magnitude long division, one quotient bit per stage.
    typedef struct packed {
        item_t                itm;
        logic                 neg;
        logic                 ovf;
        logic [DW-1:0]        den;
        logic [DW-1:0]        rem;
        logic [QW-1:0]        num_lo;
        logic [QW-1:0]        quo;
    } div_t;

    // Clip a wide signed value to the data range.
    function automatic data_t sat_data(input logic signed [31:0] x);
        data_t r;
        if (x > 32'(DATA_MAX)) begin
            r = DATA_MAX;
        end else if (x < 32'(DATA_MIN)) begin
            r = DATA_MIN;
        end else begin
            r = data_t'(x);
        end
        return r;
    endfunction

endpackage

[rtl/zou_he_boundary_node.sv]
// Channel   | Handshake                 | Words
// ----------+---------------------------+---------------------------------------------
// dist      | dist_valid / dist_stall   | nine distributions f0..f8, last_node
// result    | result_valid/result_stall | three unknowns, density, velocities, last_out
// cfg       | cfg_valid / cfg_ready     | cfg_index, cfg_data (always ready)
//
// One node enters per cycle while dist_stall is low; a word passes stage A, the
// divider entry, the 25-stage radix-2 divider (density or normal velocity),
// stages C to F and the output register. Reset clears all valid bits and loads the
// register defaults. A stage holds its word while the next stage is full and stalled;
// empty stages keep filling, so the input stalls only once the whole pipe is full.
module zou_he_boundary_node (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  zhb_pkg::cfg_idx_t    cfg_index,
    input  logic [23:0]          cfg_data,
    input  logic                 dist_valid,
    output logic                 dist_stall,
    input  zhb_pkg::data_t       dist_rest,
    input  zhb_pkg::data_t       dist_east,
    input  zhb_pkg::data_t       dist_north,
    input  zhb_pkg::data_t       dist_west,
    input  zhb_pkg::data_t       dist_south,
    input  zhb_pkg::data_t       dist_northeast,
    input  zhb_pkg::data_t       dist_northwest,
    input  zhb_pkg::data_t       dist_southwest,
    input  zhb_pkg::data_t       dist_southeast,
    input  logic                 last_node,
    output logic                 result_valid,
    input  logic                 result_stall,
    output zhb_pkg::data_t       unknown_normal,
    output zhb_pkg::data_t       unknown_diag_low,
    output zhb_pkg::data_t       unknown_diag_high,
    output zhb_pkg::data_t       node_density,
    output zhb_pkg::data_t       node_vel_x,
    output zhb_pkg::data_t       node_vel_y,
    output logic                 last_out
);
    import zhb_pkg::*;

    // Configuration registers.
    logic [1:0]      side_reg;
    logic            mode_reg;
    data_t           vx_reg;
    data_t           vy_reg;
    logic [DW-2:0]   rho_cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            side_reg    <= SIDE_SOUTH;
            mode_reg    <= MODE_VELOCITY;
            vx_reg      <= '0;
            vy_reg      <= '0;
            rho_cfg_reg <= (DW-1)'(FX_ONE);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_SIDE:    side_reg    <= cfg_data[1:0];
                REG_MODE:    mode_reg    <= cfg_data[0];
                REG_VEL_X:   vx_reg      <= data_t'(cfg_data);
                REG_VEL_Y:   vy_reg      <= data_t'(cfg_data);
                REG_DENSITY: rho_cfg_reg <= cfg_data[DW-2:0];
                default:     ;
            endcase
        end
    end

    // Side decode used by several stages; the registers must only change while idle, which the block does not enforce.
    logic ynormal;
    logic sgn_pos;
    data_t n_cfg;
    data_t t_cfg;
    assign ynormal = (side_reg == SIDE_SOUTH) || (side_reg == SIDE_NORTH);
    assign sgn_pos = (side_reg == SIDE_SOUTH) || (side_reg == SIDE_WEST);
    assign n_cfg   = ynormal ? vy_reg : vx_reg;
    assign t_cfg   = ynormal ? vx_reg : vy_reg;

    // Valid bits and load enables of every stage.
    logic a_valid_reg, c_valid_reg, d_valid_reg, e_valid_reg, f_valid_reg, o_valid_reg;
    logic div_valid_reg [0:QW];
    logic en_a, en_c, en_d, en_e, en_f, en_o;
    logic en_div [0:QW];

    assign en_o = !o_valid_reg || !result_stall;
    assign en_f = !f_valid_reg || en_o;
    assign en_e = !e_valid_reg || en_f;
    assign en_d = !d_valid_reg || en_e;
    assign en_c = !c_valid_reg || en_d;
    assign en_div[QW] = !div_valid_reg[QW] || en_c;
    for (genvar k = QW - 1; k >= 0; k--) begin : g_en
        assign en_div[k] = !div_valid_reg[k] || en_div[k+1];
    end
    assign en_a = !a_valid_reg || en_div[0];
    assign dist_stall = !en_a;

    // Stage A: pick the side's distributions and form the weighted sum.
    item_t a_next, a_reg;
    logic signed [DW+3:0] s_next, s_reg;
    logic signed [DW+3:0] tsum, osum;

    always_comb begin
        a_next.last = last_node;
        unique case (side_reg)
            SIDE_SOUTH:
            begin
                a_next.fo = dist_south;
                a_next.fp = dist_southwest;
                a_next.fm = dist_southeast;
                osum = 28'(dist_south) + 28'(dist_southwest) + 28'(dist_southeast);
            end
            SIDE_NORTH:
            begin
                a_next.fo = dist_north;
                a_next.fp = dist_northwest;
                a_next.fm = dist_northeast;
                osum = 28'(dist_north) + 28'(dist_northeast) + 28'(dist_northwest);
            end
            SIDE_WEST:
            begin
                a_next.fo = dist_west;
                a_next.fp = dist_southwest;
                a_next.fm = dist_northwest;
                osum = 28'(dist_west) + 28'(dist_northwest) + 28'(dist_southwest);
            end
            default:
            begin
                a_next.fo = dist_east;
                a_next.fp = dist_southeast;
                a_next.fm = dist_northeast;
                osum = 28'(dist_east) + 28'(dist_northeast) + 28'(dist_southeast);
            end
        endcase
        if (ynormal) begin
            tsum = 28'(dist_rest) + 28'(dist_east) + 28'(dist_west);
            a_next.d = (DW+1)'(dist_east) - (DW+1)'(dist_west);
        end else begin
            tsum = 28'(dist_rest) + 28'(dist_north) + 28'(dist_south);
            a_next.d = (DW+1)'(dist_north) - (DW+1)'(dist_south);
        end
        s_next = tsum + (osum <<< 1);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            a_valid_reg <= 1'b0;
        end else if (en_a) begin
            a_valid_reg <= dist_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (en_a && dist_valid) begin
            a_reg <= a_next;
            s_reg <= s_next;
        end
    end

    // Divider entry: divisor, magnitudes, sign and the overflow precheck.
    div_t div_reg [0:QW];
    div_t b_next;
    logic signed [DW:0] den_s;
    logic [DW+2:0] s_mag;

    always_comb begin
        if (mode_reg == MODE_VELOCITY) begin
            den_s = sgn_pos ? ((DW+1)'(FX_ONE) - (DW+1)'(n_cfg))
                            : ((DW+1)'(FX_ONE) + (DW+1)'(n_cfg));
        end else begin
            den_s = $signed({2'b00, rho_cfg_reg});
        end
        s_mag        = s_reg[DW+3] ? (DW+3)'(-s_reg) : (DW+3)'(s_reg);
        b_next.itm   = a_reg;
        b_next.den   = den_s[DW] ? DW'(-den_s) : DW'(den_s);
        b_next.neg   = s_reg[DW+3] ^ den_s[DW];
        b_next.rem   = DW'(s_mag[DW+2:QW-FB]);
        b_next.num_lo = {s_mag[QW-FB-1:0], FB'(0)};
        b_next.quo   = '0;
        b_next.ovf   = DW'(s_mag[DW+2:QW-FB]) >= b_next.den;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            div_valid_reg[0] <= 1'b0;
        end else if (en_div[0]) begin
            div_valid_reg[0] <= a_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (en_div[0] && a_valid_reg) begin
            div_reg[0] <= b_next;
        end
    end

    // Restoring division, one quotient bit per stage.
    for (genvar k = 0; k < QW; k++) begin : g_div
        logic [DW:0]   part;
        logic [DW+1:0] trial;
        div_t          step_next;

        always_comb begin
            step_next = div_reg[k];
            part  = {div_reg[k].rem, div_reg[k].num_lo[QW-1]};
            trial = {1'b0, part} - {2'b00, div_reg[k].den};
            step_next.num_lo = {div_reg[k].num_lo[QW-2:0], 1'b0};
            step_next.quo    = {div_reg[k].quo[QW-2:0], !trial[DW+1]};
            step_next.rem    = trial[DW+1] ? part[DW-1:0] : trial[DW-1:0];
        end

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n) begin
                div_valid_reg[k+1] <= 1'b0;
            end else if (en_div[k+1]) begin
                div_valid_reg[k+1] <= div_valid_reg[k];
            end
        end

        always_ff @(posedge clk) begin
            if (en_div[k+1] && div_valid_reg[k]) begin
                div_reg[k+1] <= step_next;
            end
        end
    end

    // Stage C: saturate the quotient, then fix density and velocities.
    div_t  dq;
    data_t quot_sat;
    data_t v_sat;
    data_t rho_c_next, n_c_next, t_c_next;
    item_t c_itm_reg;
    data_t rho_c_reg, n_c_reg, t_c_reg;

    assign dq = div_reg[QW];

    always_comb begin
        if (dq.ovf) begin
            quot_sat = dq.neg ? DATA_MIN : DATA_MAX;
        end else if (dq.neg) begin
            quot_sat = (dq.quo > QW'(1 << (DW - 1))) ? DATA_MIN : DW'(-dq.quo);
        end else begin
            quot_sat = (dq.quo > QW'(DATA_MAX)) ? DATA_MAX : DW'(dq.quo);
        end
        v_sat = sat_data(32'(FX_ONE) - 32'(quot_sat));
        t_c_next = t_cfg;
        if (mode_reg == MODE_VELOCITY) begin
            rho_c_next = quot_sat;
            n_c_next   = n_cfg;
        end else begin
            rho_c_next = data_t'({1'b0, rho_cfg_reg});
            if (sgn_pos) begin
                n_c_next = v_sat;
            end else begin
                n_c_next = (v_sat == DATA_MIN) ? DATA_MAX : -v_sat;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            c_valid_reg <= 1'b0;
        end else if (en_c) begin
            c_valid_reg <= div_valid_reg[QW];
        end
    end

    always_ff @(posedge clk) begin
        if (en_c && div_valid_reg[QW]) begin
            c_itm_reg <= dq.itm;
            rho_c_reg <= rho_c_next;
            n_c_reg   <= n_c_next;
            t_c_reg   <= t_c_next;
        end
    end

    // Stage D: the two products of density with the velocities.
    item_t d_itm_reg;
    data_t rho_d_reg, n_d_reg, t_d_reg;
    prod_t rn_reg, rt_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            d_valid_reg <= 1'b0;
        end else if (en_d) begin
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (en_d && c_valid_reg) begin
            d_itm_reg <= c_itm_reg;
            rho_d_reg <= rho_c_reg;
            n_d_reg   <= n_c_reg;
            t_d_reg   <= t_c_reg;
            rn_reg    <= prod_t'(rho_c_reg) * prod_t'(n_c_reg);
            rt_reg    <= prod_t'(rho_c_reg) * prod_t'(t_c_reg);
        end
    end

    // Stage E: Zou/He sums in units of one sixth of a step, with the half-step bias.
    localparam acc_t THREE_ONE = acc_t'(3) <<< FB;
    acc_t snr;
    acc_t acc_norm_next, acc_plus_next, acc_minus_next;
    acc_t acc_norm_reg, acc_plus_reg, acc_minus_reg;
    data_t rho_e_reg, n_e_reg, t_e_reg;
    logic last_e_reg;

    always_comb begin
        snr = sgn_pos ? acc_t'(rn_reg) : -acc_t'(rn_reg);
        acc_norm_next  = ((acc_t'(d_itm_reg.fo) * 6) <<< FB) + (snr <<< 2) + THREE_ONE;
        acc_plus_next  = ((acc_t'(d_itm_reg.fp) * 6) <<< FB)
                       - ((acc_t'(d_itm_reg.d) * 3) <<< FB)
                       + acc_t'(rt_reg) * 3 + snr + THREE_ONE;
        acc_minus_next = ((acc_t'(d_itm_reg.fm) * 6) <<< FB)
                       + ((acc_t'(d_itm_reg.d) * 3) <<< FB)
                       - acc_t'(rt_reg) * 3 + snr + THREE_ONE;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            e_valid_reg <= 1'b0;
        end else if (en_e) begin
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (en_e && d_valid_reg) begin
            acc_norm_reg  <= acc_norm_next;
            acc_plus_reg  <= acc_plus_next;
            acc_minus_reg <= acc_minus_next;
            rho_e_reg     <= rho_d_reg;
            n_e_reg       <= n_d_reg;
            t_e_reg       <= t_d_reg;
            last_e_reg    <= d_itm_reg.last;
        end
    end

    // Stage F: floor divide by six as a shift, a bias and a reciprocal multiply by three.
    function automatic logic [FW-1:0] div3_floor(input acc_t acc);
        logic signed [YW-1:0] y;
        logic [YW-1:0]        u;
        logic [PW-1:0]        p;
        y = YW'(acc >>> (FB + 1));
        u = $unsigned(y) + YW'(3 << BIAS_SH);
        p = PW'(u) * PW'(RECIP3);
        return p[PW-1:RECIP_SH];
    endfunction

    logic [FW-1:0] fl_norm_reg, fl_plus_reg, fl_minus_reg;
    data_t rho_f_reg, n_f_reg, t_f_reg;
    logic last_f_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            f_valid_reg <= 1'b0;
        end else if (en_f) begin
            f_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (en_f && e_valid_reg) begin
            fl_norm_reg  <= div3_floor(acc_norm_reg);
            fl_plus_reg  <= div3_floor(acc_plus_reg);
            fl_minus_reg <= div3_floor(acc_minus_reg);
            rho_f_reg    <= rho_e_reg;
            n_f_reg      <= n_e_reg;
            t_f_reg      <= t_e_reg;
            last_f_reg   <= last_e_reg;
        end
    end

    // Output register: remove the bias, saturate and map to the side's ordering.
    function automatic data_t unbias(input logic [FW-1:0] fl);
        return sat_data($signed(32'(fl)) - 32'(1 << BIAS_SH));
    endfunction

    data_t plus_o, minus_o;
    data_t unorm_reg, lo_reg, hi_reg, rho_o_reg, vx_o_reg, vy_o_reg;
    logic last_o_reg;

    assign plus_o  = unbias(fl_plus_reg);
    assign minus_o = unbias(fl_minus_reg);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            o_valid_reg <= 1'b0;
        end else if (en_o) begin
            o_valid_reg <= f_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (en_o && f_valid_reg) begin
            unorm_reg  <= unbias(fl_norm_reg);
            lo_reg     <= (side_reg == SIDE_NORTH) ? minus_o : plus_o;
            hi_reg     <= (side_reg == SIDE_NORTH) ? plus_o : minus_o;
            rho_o_reg  <= rho_f_reg;
            vx_o_reg   <= ynormal ? t_f_reg : n_f_reg;
            vy_o_reg   <= ynormal ? n_f_reg : t_f_reg;
            last_o_reg <= last_f_reg;
        end
    end

    assign result_valid      = o_valid_reg;
    assign unknown_normal    = unorm_reg;
    assign unknown_diag_low  = lo_reg;
    assign unknown_diag_high = hi_reg;
    assign node_density      = rho_o_reg;
    assign node_vel_x        = vx_o_reg;
    assign node_vel_y        = vy_o_reg;
    assign last_out          = last_o_reg;

    // The input is held off only while the first stage carries a word.
    a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        dist_stall |-> a_valid_reg)
        else $error("input stalled with an empty first stage");

    // A word held in the first stage is not dropped.
    a_word_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && dist_stall) |=> a_valid_reg)
        else $error("first stage lost a held word");

    // A stalled result keeps its last stage from advancing, so the divider end holds too.
    a_div_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (div_valid_reg[QW] && !en_div[QW]) |=> (div_valid_reg[QW] && $stable(div_reg[QW])))
        else $error("divider output changed while held");

endmodule

[tb/sv/tb_zou_he_boundary_node.sv]
`timescale 1ns / 100ps

module tb_zou_he_boundary_node;
    import zhb_pkg::*;

    localparam int LATENCY = 40;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam longint QMAX = 64'sd8388607;
    localparam longint QMIN = -64'sd8388608;
    localparam longint ONE = 64'sd1048576;

    // One boundary node on its way in.
    typedef struct {
        data_t f [9];
        logic  last;
    } node_word_t;

    // One word of boundary result.
    typedef struct {
        data_t unorm;
        data_t dlo;
        data_t dhi;
        data_t rho;
        data_t vx;
        data_t vy;
        logic  last;
    } bnd_word_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    cfg_idx_t    cfg_index;
    logic [23:0] cfg_data;
    logic        dist_valid;
    logic        dist_stall;
    data_t       dist_in [9];
    logic        last_node;
    logic        result_valid;
    logic        result_stall;
    data_t       unknown_normal;
    data_t       unknown_diag_low;
    data_t       unknown_diag_high;
    data_t       node_density;
    data_t       node_vel_x;
    data_t       node_vel_y;
    logic        last_out;

    // Local copy of the boundary registers.
    logic [1:0]  side_q;
    logic        mode_q;
    longint      vel_x_q;
    longint      vel_y_q;
    longint      density_q;

    node_word_t  pending_nodes [$];
    bnd_word_t   expected_results [$];
    int          error_count;
    int          idle_cycles;
    bit          drain_hold;
    int          send_gap;
    int          stall_gap;

    zou_he_boundary_node DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .dist_valid(dist_valid), .dist_stall(dist_stall),
        .dist_rest(dist_in[0]), .dist_east(dist_in[1]), .dist_north(dist_in[2]),
        .dist_west(dist_in[3]), .dist_south(dist_in[4]),
        .dist_northeast(dist_in[5]), .dist_northwest(dist_in[6]),
        .dist_southwest(dist_in[7]), .dist_southeast(dist_in[8]),
        .last_node(last_node),
        .result_valid(result_valid), .result_stall(result_stall),
        .unknown_normal(unknown_normal), .unknown_diag_low(unknown_diag_low),
        .unknown_diag_high(unknown_diag_high), .node_density(node_density),
        .node_vel_x(node_vel_x), .node_vel_y(node_vel_y), .last_out(last_out)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic longint clip(longint x);
        if (x > QMAX) return QMAX;
        if (x < QMIN) return QMIN;
        return x;
    endfunction

    function automatic longint divide_sat(longint num, longint den);
        if (den == 0) return (num < 0) ? QMIN : QMAX;
        return clip(num / den);
    endfunction

    // Accumulator is in sixths of a fraction step; round half up.
    function automatic longint round_sixth(longint acc);
        longint b;
        longint a;
        longint q;
        b = 6 * ONE;
        a = acc + 3 * ONE;
        q = a / b;
        if ((a % b) != 0 && a < 0) q--;
        return clip(q);
    endfunction

    // Zou/He closure for the configured side and condition.
    function automatic bnd_word_t zou_he_predict(node_word_t w);
        bnd_word_t r;
        longint f [9];
        longint fo, fp, fm, tsum, osum, d, sgn, n, t, rho, rn, rt, pl, mi, q;
        bit ynorm;
        for (int i = 0; i < 9; i++) f[i] = w.f[i];
        case (side_q)
            SIDE_SOUTH: begin fo = f[4]; fp = f[7]; fm = f[8]; sgn = 1; ynorm = 1; end
            SIDE_NORTH: begin fo = f[2]; fp = f[6]; fm = f[5]; sgn = -1; ynorm = 1; end
            SIDE_WEST:  begin fo = f[3]; fp = f[7]; fm = f[6]; sgn = 1; ynorm = 0; end
            default:    begin fo = f[1]; fp = f[8]; fm = f[5]; sgn = -1; ynorm = 0; end
        endcase
        case (side_q)
            SIDE_SOUTH: osum = f[4] + f[7] + f[8];
            SIDE_NORTH: osum = f[2] + f[5] + f[6];
            SIDE_WEST:  osum = f[3] + f[6] + f[7];
            default:    osum = f[1] + f[5] + f[8];
        endcase
        if (ynorm) begin
            tsum = f[0] + f[1] + f[3]; d = f[1] - f[3]; t = vel_x_q;
        end else begin
            tsum = f[0] + f[2] + f[4]; d = f[2] - f[4]; t = vel_y_q;
        end
        if (mode_q == MODE_VELOCITY) begin
            n = ynorm ? vel_y_q : vel_x_q;
            rho = divide_sat((tsum + 2 * osum) * ONE, ONE - sgn * n);
        end else begin
            rho = density_q;
            q = divide_sat((tsum + 2 * osum) * ONE, rho);
            n = clip(sgn * clip(ONE - q));
        end
        rn = rho * n;
        rt = rho * t;
        r.unorm = data_t'(round_sixth(6 * ONE * fo + sgn * 4 * rn));
        pl = round_sixth(6 * ONE * fp - 3 * ONE * d + 3 * rt + sgn * rn);
        mi = round_sixth(6 * ONE * fm + 3 * ONE * d - 3 * rt + sgn * rn);
        r.dlo = data_t'((side_q == SIDE_NORTH) ? mi : pl);
        r.dhi = data_t'((side_q == SIDE_NORTH) ? pl : mi);
        r.rho = data_t'(rho);
        r.vx = data_t'(ynorm ? t : n);
        r.vy = data_t'(ynorm ? n : t);
        r.last = w.last;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        error_count++;
    endtask

    function automatic int pick_gap();
        if ($urandom_range(0, 2) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 60);
        return $urandom_range(0, 3);
    endfunction

    // Driver: presents pending nodes, keeps a word steady while stalled.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            dist_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (!dist_valid || !dist_stall) begin
                if (dist_valid) begin
                    expected_results.push_back(zou_he_predict(pending_nodes.pop_front()));
                end
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    dist_valid <= 1'b0;
                end else if (pending_nodes.size() > 0 && !drain_hold) begin
                    node_word_t w;
                    w = pending_nodes[0];
                    for (int i = 0; i < 9; i++) dist_in[i] <= w.f[i];
                    last_node <= w.last;
                    dist_valid <= 1'b1;
                    send_gap <= pick_gap();
                end else begin
                    dist_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random stall, field by field compare.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            result_stall <= 1'b0;
            stall_gap <= 0;
        end else begin
            if (result_valid && !result_stall) begin
                if (expected_results.size() == 0) begin
                    $display("unexpected result word at %0t", $time);
                    error_count++;
                end else begin
                    bnd_word_t e;
                    e = expected_results.pop_front();
                    if (unknown_normal !== e.unorm)
                        report_mismatch("unknown_normal", unknown_normal, e.unorm);
                    if (unknown_diag_low !== e.dlo)
                        report_mismatch("unknown_diag_low", unknown_diag_low, e.dlo);
                    if (unknown_diag_high !== e.dhi)
                        report_mismatch("unknown_diag_high", unknown_diag_high, e.dhi);
                    if (node_density !== e.rho)
                        report_mismatch("node_density", node_density, e.rho);
                    if (node_vel_x !== e.vx)
                        report_mismatch("node_vel_x", node_vel_x, e.vx);
                    if (node_vel_y !== e.vy)
                        report_mismatch("node_vel_y", node_vel_y, e.vy);
                    if (last_out !== e.last)
                        report_mismatch("last_out", last_out, e.last);
                end
            end
            if (stall_gap > 0) begin
                stall_gap <= stall_gap - 1;
                result_stall <= 1'b1;
            end else begin
                result_stall <= 1'b0;
                if ($urandom_range(0, 5) == 0) stall_gap <= pick_gap();
            end
        end
    end

    // Watchdog on cycles with no accepted word on either side.
    always @(posedge clk)
    begin
        if ((dist_valid && !dist_stall) || (result_valid && !result_stall)
                || (pending_nodes.size() == 0 && expected_results.size() == 0)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_zou_he_boundary_node failed");
                $finish;
            end
        end
    end

    function automatic data_t rand_dist();
        case ($urandom_range(0, 5))
            0: return DATA_MAX;
            1: return DATA_MIN;
            2: return data_t'($urandom);
            default: return data_t'($signed(24'($urandom_range(0, 300000))) - 150000);
        endcase
    endfunction

    task automatic queue_node(bit extreme);
        node_word_t w;
        for (int i = 0; i < 9; i++) w.f[i] = extreme ? rand_dist()
            : data_t'(longint'($urandom_range(0, 400000)) - 100000);
        w.last = 1'($urandom_range(0, 1));
        pending_nodes.push_back(w);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [23:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_SIDE:    side_q = val[1:0];
            REG_MODE:    mode_q = val[0];
            REG_VEL_X:   vel_x_q = longint'($signed(val));
            REG_VEL_Y:   vel_y_q = longint'($signed(val));
            default:     density_q = longint'(val[22:0]);
        endcase
    endtask

    // Let everything in flight come out, then the pipe latency.
    task automatic drain();
        wait (pending_nodes.size() == 0 && !dist_valid && expected_results.size() == 0);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic run_phase(int count, bit extreme);
        for (int i = 0; i < count; i++) queue_node(extreme);
        drain();
    endtask

    function automatic logic [23:0] rand_vel();
        case ($urandom_range(0, 6))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'(ONE);
            3: return 24'(-ONE);
            4: return 24'($urandom);
            default: return 24'($urandom_range(0, 400000) - 200000);
        endcase
    endfunction

    function automatic logic [23:0] rand_density();
        case ($urandom_range(0, 4))
            0: return 24'd1;
            1: return 24'h7FFFFF;
            2: return 24'(ONE);
            default: return 24'($urandom_range(1, 8388607));
        endcase
    endfunction

    initial
    begin
        node_word_t w;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_SIDE;
        cfg_data = '0;
        for (int i = 0; i < 9; i++) dist_in[i] = '0;
        last_node = 1'b0;
        error_count = 0;
        idle_cycles = 0;
        drain_hold = 1'b0;
        side_q = SIDE_SOUTH;
        mode_q = MODE_VELOCITY;
        vel_x_q = 0;
        vel_y_q = 0;
        density_q = ONE;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset defaults, field extremes, every side and mode.
        for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 9; i++) w.f[i] = (k == 0) ? DATA_MAX : (k == 1) ? DATA_MIN : '0;
            w.last = k[0];
            pending_nodes.push_back(w);
        end
        drain();
        for (int s = 0; s < 4; s++) begin
            for (int m = 0; m < 2; m++) begin
                write_reg(REG_SIDE, 24'(s));
                write_reg(REG_MODE, 24'(m));
                write_reg(REG_VEL_X, 24'(ONE / 10));
                // A normal velocity of plus one (south) or minus one (north) gives a zero divisor in velocity mode.
                write_reg(REG_VEL_Y, (s < 2) ? 24'(s == 0 ? ONE : -ONE) : 24'(-ONE / 20));
                write_reg(REG_DENSITY, (s == 3) ? 24'd1 : 24'(ONE));
                run_phase(2, 1);
            end
        end
        write_reg(REG_SIDE, SIDE_WEST);
        write_reg(REG_MODE, MODE_VELOCITY);
        write_reg(REG_VEL_X, 24'(2 * ONE));
        run_phase(2, 0);

        // Random phases with fresh register settings.
        for (int p = 0; p < 22; p++) begin
            write_reg(REG_SIDE, 24'($urandom_range(0, 3)));
            write_reg(REG_MODE, 24'($urandom_range(0, 1)));
            write_reg(REG_VEL_X, rand_vel());
            write_reg(REG_VEL_Y, rand_vel());
            write_reg(REG_DENSITY, rand_density());
            for (int i = 0; i < 25; i++) queue_node($urandom_range(0, 3) == 0);
            if (p == 5) begin
                // Sender holds off until the pipe is empty.
                wait (pending_nodes.size() < 12);
                drain_hold = 1'b1;
                wait (!dist_valid && expected_results.size() == 0);
                drain_hold = 1'b0;
            end
            drain();
        end

        if (error_count == 0) begin
            $display("tb_zou_he_boundary_node passed");
        end else begin
            $display("tb_zou_he_boundary_node failed");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/zhb_pkg.sv
rtl/zou_he_boundary_node.sv
tb/sv/tb_zou_he_boundary_node.sv
